// ----- hw/rtl/b64e_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// b64e_pkg
// Types, constants and the digit mapping shared by the lsb-first base64 encoder
// ----------------------------------------------------------------------------
package b64e_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned GROUP_W = 6;
  localparam int unsigned CHAR_W  = 7;
  localparam int unsigned ACC_W   = 2 * GROUP_W;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'd48;  // '0'
  localparam logic [CHAR_W-1:0] CHAR_LOW_A = 7'd97;  // 'a'
  localparam logic [CHAR_W-1:0] CHAR_UP_A  = 7'd65;  // 'A'
  localparam logic [CHAR_W-1:0] CHAR_DASH  = 7'd45;  // '-'
  localparam logic [CHAR_W-1:0] CHAR_EQ    = 7'd61;  // '='

  localparam logic [2:0] CNT_NONE = 3'd0;
  localparam logic [2:0] CNT_TWO  = 3'd2;
  localparam logic [2:0] CNT_FOUR = 3'd4;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              end_of_message;
  } in_item_t;

  typedef struct packed {
    logic [CHAR_W-1:0] digit_char;
    logic              last_digit;
  } out_item_t;

  // groups of one byte: group 0 in the low bits, group 1 above it, zero-padded when not full
  typedef struct packed {
    logic [ACC_W-1:0] groups;
    logic             two;
    logic             last;
  } pack_t;

  function automatic logic [CHAR_W-1:0] to_digit(input logic [GROUP_W-1:0] v);
    logic [CHAR_W-1:0] vx;
    vx = {1'b0, v};
    if (v < 6'd10)       return vx + CHAR_ZERO;
    else if (v < 6'd36)  return vx - 7'd10 + CHAR_LOW_A;
    else if (v < 6'd62)  return vx - 7'd36 + CHAR_UP_A;
    else if (v == 6'd62) return CHAR_DASH;
    else                 return CHAR_EQ;
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/b64e_packer.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// b64e_packer
// Appends a byte to the pending stream bits and splits it into 6-bit groups
// ----------------------------------------------------------------------------
module b64e_packer
  import b64e_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     take,
  input  wire in_item_t item,
  output pack_t         pack
);

  logic [3:0]       leftover_bits;
  logic [2:0]       leftover_count;
  logic [3:0]       leftover_bits_next;
  logic [2:0]       leftover_count_next;
  logic [ACC_W-1:0] acc;
  logic             four_pending;

  always_comb begin
    four_pending        = 1'b0;
    leftover_bits_next  = 4'd0;
    leftover_count_next = CNT_NONE;
    case (leftover_count)
      CNT_NONE: begin
        acc                 = {4'd0, item.data_byte};
        leftover_bits_next  = {2'b00, item.data_byte[7:6]};
        leftover_count_next = CNT_TWO;
      end
      CNT_TWO: begin
        acc                 = {2'd0, item.data_byte, leftover_bits[1:0]};
        leftover_bits_next  = item.data_byte[7:4];
        leftover_count_next = CNT_FOUR;
      end
      default: begin
        acc          = {item.data_byte, leftover_bits};
        four_pending = 1'b1;
      end
    endcase
    if (item.end_of_message) begin
      leftover_bits_next  = 4'd0;
      leftover_count_next = CNT_NONE;
    end
    pack.groups = acc;
    // a second digit appears with four pending bits; a padded one only on the last byte
    pack.two    = four_pending || item.end_of_message;
    pack.last   = item.end_of_message;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      leftover_bits  <= 4'd0;
      leftover_count <= CNT_NONE;
    end else if (take) begin
      leftover_bits  <= leftover_bits_next;
      leftover_count <= leftover_count_next;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/base64_lsb_first_encoder.sv -----
// Each byte is registered in the digit stage, each of its digits then in the
// output register, a second digit (if any) after the first. Throughput: one
// byte per cycle, set by the single digit-per-cycle output register, when it
// yields one digit and out_ready holds; else in_ready waits on the last digit.
// Reset: synchronous, clears pending bits, the digit stage and the output.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// base64_lsb_first_encoder
// Byte stream to base64 digits, bits taken least significant first
// ----------------------------------------------------------------------------
module base64_lsb_first_encoder
  import b64e_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_data,
  input  wire logic      out_ready,
  output logic           out_valid,
  output out_item_t      out_data
);

  pack_t            pack;
  logic             take;
  logic             stg_valid;
  logic [ACC_W-1:0] stg_groups;
  logic             stg_two;
  logic             stg_last;
  logic             stg_idx;
  logic             out_load;
  logic             emit;
  logic             stg_done;
  logic [GROUP_W-1:0] group_sel;

  b64e_packer u_packer (
    .clk  (clk),
    .rst  (rst),
    .take (take),
    .item (in_data),
    .pack (pack)
  );

  assign out_load  = !out_valid || out_ready;
  assign emit      = stg_valid && out_load;
  assign stg_done  = emit && (stg_idx || !stg_two);
  assign in_ready  = !stg_valid || stg_done;
  assign take      = in_valid && in_ready;
  assign group_sel = stg_idx ? stg_groups[ACC_W-1:GROUP_W] : stg_groups[GROUP_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
      stg_idx   <= 1'b0;
    end else if (take) begin
      stg_valid <= 1'b1;
      stg_idx   <= 1'b0;
    end else if (stg_done) begin
      stg_valid <= 1'b0;
      stg_idx   <= 1'b0;
    end else if (emit) begin
      stg_idx   <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      stg_groups <= pack.groups;
      stg_two    <= pack.two;
      stg_last   <= pack.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data.digit_char <= to_digit(group_sel);
      out_data.last_digit <= stg_last && (stg_idx || !stg_two);
    end
  end

`ifndef SYNTHESIS
  // while the stage holds a byte, a new one only enters as it hands over its final digit
  a_ready_only_on_drain: assert property (@(posedge clk) disable iff (rst)
    (in_ready && stg_valid) |-> stg_done)
    else $error("input ready while digit stage still busy");

  a_idx_needs_two: assert property (@(posedge clk) disable iff (rst)
    (stg_valid && stg_idx) |-> stg_two)
    else $error("second digit selected for a one-digit byte");

  a_emit_shows_output: assert property (@(posedge clk) disable iff (rst)
    emit |=> out_valid)
    else $error("emitted digit missing from output register");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> (!out_valid && !stg_valid))
    else $error("reset left a digit pending");
`endif

endmodule
`default_nettype wire
